// File: rtl/cac_pkg.sv
// Shared types and codes for the card access controller.
// No dependencies; imported by cac_cell and the top level.
`timescale 1ns / 1ps

package cac_pkg;

   // Item kinds on the request channel
   localparam logic REQ_CARD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Event codes on the response channel
   localparam logic [2:0] EV_NONE          = 3'd0;
   localparam logic [2:0] EV_REJECT        = 3'd1;
   localparam logic [2:0] EV_USER          = 3'd2;
   localparam logic [2:0] EV_ADMIN_OPEN    = 3'd3;
   localparam logic [2:0] EV_ADMIN_CLOSE   = 3'd4;
   localparam logic [2:0] EV_ADDED         = 3'd5;
   localparam logic [2:0] EV_TIMEOUT       = 3'd6;
   localparam logic [2:0] EV_KNOWN_IGNORED = 3'd7;

   // Beeper patterns
   localparam logic [1:0] BEEP_NONE       = 2'd0;
   localparam logic [1:0] BEEP_LONG       = 2'd1;
   localparam logic [1:0] BEEP_LONG_SHORT = 2'd2;
   localparam logic [1:0] BEEP_SHORT3     = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADMIN_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd300;

   typedef struct packed {
      logic        req_type;
      logic [31:0] card_id;
   } req_item_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic       door_open;
      logic [1:0] beep_pattern;
      logic       save_table;
      logic       enroll_active;
      logic [3:0] users_enrolled;
   } rsp_item_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic [31:0] id;
      logic        hit;
   } probe_type;

endpackage

// File: rtl/cac_cell.sv
// One slot of the user table: holds an ID and checks the passing search token.
// Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_cell (
   input  logic              clock,
   input  logic              reset,
   input  cac_pkg::probe_type probe_i,
   output cac_pkg::probe_type probe_o,
   input  logic              filled,
   input  logic              wr_en,
   input  logic [31:0]       wr_id
);
   import cac_pkg::*;

   logic [31:0] entry_ff;
   probe_type   probe_ff;
   probe_type   probe_in;

   // Merge this slot's match into the token
   always_comb begin
      probe_in       = probe_i;
      probe_in.hit   = probe_i.hit | (filled && (entry_ff == probe_i.id));
   end

   // Hold the entry; advance the token one cell per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_id;
      end
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in.valid;
      end
      probe_ff.id  <= probe_in.id;
      probe_ff.hit <= probe_in.hit;
   end

   assign probe_o = probe_ff;

endmodule

// File: rtl/card_access_controller_with_enroll_top.sv
// Card access controller with enrolment: control, registers and the cell row.
// Depends on cac_pkg and cac_cell.
// A card's result is registered once the search token has walked the row of MAX_USERS cells
// and the control has stepped through S_SEARCH and S_FINISH; a tick goes straight to S_FINISH.
// One item in flight; the next item is taken the cycle after the result registers, and the
// result waits in S_FINISH while the previous result is stalled.
// Reset (synchronous, active high): empty table count, enrol mode off, countdown zero,
// admin ID zero, timeout 300 s. Table entries are not cleared and are never read unfilled.
`timescale 1ns / 1ps

module card_access_controller_with_enroll_top #(
   parameter int unsigned MAX_USERS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cac_pkg::req_item_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cac_pkg::rsp_item_type          rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata
);
   import cac_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_USERS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_USERS);
   localparam logic [CNT_W-1:0] SLOT_TOP = CNT_W'(MAX_USERS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_FINISH
   } state_type;

   state_type    state_ff, state_in;
   req_item_type req_ff, req_in;
   logic         hit_ff, hit_in;
   logic [31:0]  admin_ff, admin_in;
   logic [15:0]  timeout_ff, timeout_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic         enroll_ff, enroll_in;
   logic [15:0]  secs_ff, secs_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   probe_type    chain [MAX_USERS+1];
   logic [MAX_USERS-1:0] wr_en;
   logic [CNT_W-1:0] wr_slot;
   logic         add_fire;
   logic         out_free;
   logic         admin_hit;
   logic [CNT_W+3:0] count_ext;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign admin_hit = (req_ff.card_id == admin_ff);

   // Launch a search token when a card is accepted
   always_comb begin
      chain[0].valid = req_valid && !req_stall && (req_data.req_type == REQ_CARD);
      chain[0].id    = req_data.card_id;
      chain[0].hit   = 1'b0;
   end

   // Row of table cells
   for (genvar g = 0; g < MAX_USERS; g++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
      cac_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .probe_i (chain[g]),
         .probe_o (chain[g+1]),
         .filled  (IDX < count_ff),
         .wr_en   (wr_en[g]),
         .wr_id   (req_ff.card_id)
      );
   end

   // Slot for a new user: next free one, or the last when full
   assign wr_slot = (count_ff < CNT_MAX) ? count_ff : SLOT_TOP;
   assign add_fire = (state_ff == S_FINISH) && out_free && (req_ff.req_type == REQ_CARD)
                     && enroll_ff && !admin_hit && !hit_ff;

   always_comb begin
      for (int i = 0; i < MAX_USERS; i++) begin
         wr_en[i] = add_fire && (wr_slot == CNT_W'(i));
      end
   end

   // Next-state logic: sequencing, decisions and register writes
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      hit_in       = hit_ff;
      admin_in     = admin_ff;
      timeout_in   = timeout_ff;
      count_in     = count_ff;
      enroll_in    = enroll_ff;
      secs_in      = secs_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      count_ext    = '0;

      unique case (csr_index)
         CSR_ADMIN_ID: if (csr_valid) admin_in = csr_wdata;
         CSR_TIMEOUT:  if (csr_valid) timeout_in = csr_wdata[15:0];
         default: ;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               hit_in   = 1'b0;
               state_in = (req_data.req_type == REQ_CARD) ? S_SEARCH : S_FINISH;
            end
         end
         S_SEARCH: begin
            if (chain[MAX_USERS].valid) begin
               hit_in   = chain[MAX_USERS].hit;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_in.event_code   = EV_NONE;
               rsp_in.door_open    = 1'b0;
               rsp_in.beep_pattern = BEEP_NONE;
               rsp_in.save_table   = 1'b0;
               if (req_ff.req_type == REQ_TICK) begin
                  if (enroll_ff) begin
                     if (secs_ff <= 16'd1) begin
                        secs_in   = '0;
                        enroll_in = 1'b0;
                        rsp_in.event_code = EV_TIMEOUT;
                        rsp_in.save_table = 1'b1;
                     end else begin
                        secs_in = secs_ff - 16'd1;
                     end
                  end
               end else if (!enroll_ff) begin
                  if (admin_hit) begin
                     rsp_in.event_code   = EV_ADMIN_OPEN;
                     rsp_in.door_open    = 1'b1;
                     rsp_in.beep_pattern = BEEP_LONG_SHORT;
                     enroll_in = 1'b1;
                     secs_in   = timeout_ff;
                  end else if (hit_ff) begin
                     rsp_in.event_code   = EV_USER;
                     rsp_in.door_open    = 1'b1;
                     rsp_in.beep_pattern = BEEP_LONG;
                  end else begin
                     rsp_in.event_code   = EV_REJECT;
                     rsp_in.beep_pattern = BEEP_SHORT3;
                  end
               end else begin
                  if (admin_hit) begin
                     rsp_in.event_code = EV_ADMIN_CLOSE;
                     rsp_in.save_table = 1'b1;
                     enroll_in = 1'b0;
                     secs_in   = '0;
                  end else if (hit_ff) begin
                     rsp_in.event_code = EV_KNOWN_IGNORED;
                  end else begin
                     rsp_in.event_code = EV_ADDED;
                     count_in = (count_ff < CNT_MAX) ? count_ff + CNT_W'(1) : CNT_MAX;
                     secs_in  = timeout_ff;
                  end
               end
               rsp_in.enroll_active  = enroll_in;
               count_ext             = {4'b0000, count_in};
               rsp_in.users_enrolled = count_ext[3:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         admin_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         count_ff     <= '0;
         enroll_ff    <= 1'b0;
         secs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         admin_ff     <= admin_in;
         timeout_ff   <= timeout_in;
         count_ff     <= count_in;
         enroll_ff    <= enroll_in;
         secs_ff      <= secs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_door_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.door_open |->
         (rsp_ff.event_code == EV_USER || rsp_ff.event_code == EV_ADMIN_OPEN))
      else $error("door opened on a non-grant event");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("user count beyond table size");

   a_token_in_search: assert property (@(posedge clock) disable iff (reset)
      chain[MAX_USERS].valid |-> state_ff == S_SEARCH)
      else $error("search token left the row outside a search");

   a_save_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.save_table |-> !rsp_ff.enroll_active)
      else $error("save strobe while enrol mode stays open");

   a_add_in_enroll: assert property (@(posedge clock) disable iff (reset)
      add_fire |=> count_ff != '0 && enroll_ff)
      else $error("table written outside enrol mode");
`endif

endmodule

// File: test/tb_card_access_controller_with_enroll_top.sv
// Self-checking testbench for card_access_controller_with_enroll_top: directed and random items.
// A local door-control predictor checks every item. Needs cac_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_card_access_controller_with_enroll_top;
   import cac_pkg::*;

   localparam int unsigned MAX_USERS   = 10;
   localparam int unsigned TAIL_WAIT   = MAX_USERS + 6;
   localparam int unsigned HOLD_LEN    = 200;
   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned POOL_SIZE   = 16;
   // Indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   // Predictor copy of registers and state
   logic [31:0] door_admin_id = '0;
   logic [15:0] door_timeout  = TIMEOUT_RESET;
   logic [31:0] known_ids [MAX_USERS];
   int unsigned n_users       = 0;
   logic        enrol_on      = 1'b0;
   logic [15:0] secs_left     = '0;

   rsp_item_type pending_events[$];
   int unsigned  mismatch_count = 0;
   int unsigned  send_idle_pct  = 30;
   int unsigned  rsp_stall_pct  = 75;
   logic         hold_req       = 1'b0;
   logic         hold_seen      = 1'b0;
   int unsigned  hold_left      = 0;
   int unsigned  quiet_cycles   = 0;
   logic [31:0]  id_pool [POOL_SIZE];

   card_access_controller_with_enroll_top #(
      .MAX_USERS(MAX_USERS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Work out the event for one item and advance the predicted state
   function automatic rsp_item_type predict_door_event(input req_item_type item);
      rsp_item_type r;
      logic         known;
      int unsigned  i;
      r = '0;
      r.event_code = EV_NONE;
      r.beep_pattern = BEEP_NONE;
      known = 1'b0;
      for (i = 0; i < n_users; i++) begin
         if (known_ids[i] == item.card_id) known = 1'b1;
      end
      if (item.req_type == REQ_TICK) begin
         if (enrol_on) begin
            if (secs_left <= 16'd1) begin
               secs_left = '0;
               enrol_on = 1'b0;
               r.event_code = EV_TIMEOUT;
               r.save_table = 1'b1;
            end else begin
               secs_left = secs_left - 16'd1;
            end
         end
      end else if (!enrol_on) begin
         if (item.card_id == door_admin_id) begin
            r.event_code = EV_ADMIN_OPEN;
            r.door_open = 1'b1;
            r.beep_pattern = BEEP_LONG_SHORT;
            enrol_on = 1'b1;
            secs_left = door_timeout;
         end else if (known) begin
            r.event_code = EV_USER;
            r.door_open = 1'b1;
            r.beep_pattern = BEEP_LONG;
         end else begin
            r.event_code = EV_REJECT;
            r.beep_pattern = BEEP_SHORT3;
         end
      end else begin
         if (item.card_id == door_admin_id) begin
            r.event_code = EV_ADMIN_CLOSE;
            r.save_table = 1'b1;
            enrol_on = 1'b0;
            secs_left = '0;
         end else if (known) begin
            r.event_code = EV_KNOWN_IGNORED;
         end else begin
            // Add the new ID; when the table is full, overwrite the last slot
            if (n_users < MAX_USERS) begin
               known_ids[n_users] = item.card_id;
               n_users++;
            end else begin
               known_ids[MAX_USERS-1] = item.card_id;
            end
            secs_left = door_timeout;
            r.event_code = EV_ADDED;
         end
      end
      r.enroll_active = enrol_on;
      r.users_enrolled = 4'(n_users);
      return r;
   endfunction

   // Receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result with nothing outstanding: %p", $time, rsp_data);
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.event_code !== want.event_code ||
                rsp_data.door_open !== want.door_open ||
                rsp_data.beep_pattern !== want.beep_pattern ||
                rsp_data.save_table !== want.save_table ||
                rsp_data.enroll_active !== want.enroll_active ||
                rsp_data.users_enrolled !== want.users_enrolled) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item, wait for it to be taken and record its prediction
   task automatic send_item(input logic kind, input logic [31:0] id);
      req_item_type item;
      item.req_type = kind;
      item.card_id = id;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      pending_events.push_back(predict_door_event(item));
   endtask

   // Drop the input and wait until every prediction has been matched
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ADMIN_ID: door_admin_id = value;
         CSR_TIMEOUT:  door_timeout = value[15:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly admin and pool cards with ticks, some unrelated cards as noise
   task automatic send_mixed_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         send_item(REQ_CARD, door_admin_id);
      else if (pick < 50)
         send_item(REQ_CARD, id_pool[$urandom_range(0, POOL_SIZE - 1)]);
      else if (pick < 62)
         send_item(REQ_CARD, $urandom);
      else
         send_item(REQ_TICK, $urandom);
   endtask

   // Reset values: admin ID zero, tick idle outside enrolment, full 300 s countdown
   task automatic test_reset_values();
      send_item(REQ_TICK, $urandom);
      send_item(REQ_CARD, 32'h0000_0001);
      send_item(REQ_CARD, 32'h0000_0000);
      repeat (TIMEOUT_RESET) send_item(REQ_TICK, $urandom);
      send_item(REQ_CARD, 32'h0000_0000);
      send_item(REQ_CARD, 32'h0000_0000);
   endtask

   // Field extremes, every event, zero countdown, full table and admin precedence
   task automatic test_edge_cases();
      logic [31:0] last_slot_id;
      logic [31:0] fresh_id;
      last_slot_id = '0;
      fresh_id = $urandom;
      write_csr(CSR_ADMIN_ID, 32'hA5C3_0F81);
      write_csr(CSR_TIMEOUT, 32'hFFFF_0000);
      write_csr(CSR_SPARE_A, 32'h0000_0007);
      write_csr(CSR_SPARE_B, 32'hFFFF_FFFF);
      send_item(REQ_CARD, 32'h0000_0000);
      send_item(REQ_CARD, 32'hFFFF_FFFF);
      send_item(REQ_TICK, 32'hFFFF_FFFF);
      // enrol both extremes, repeat one, then a tick closes on a zero countdown
      send_item(REQ_CARD, door_admin_id);
      send_item(REQ_CARD, 32'h0000_0000);
      send_item(REQ_CARD, 32'hFFFF_FFFF);
      send_item(REQ_CARD, 32'h0000_0000);
      send_item(REQ_TICK, 32'h0000_0000);
      send_item(REQ_CARD, 32'h0000_0000);
      send_item(REQ_CARD, 32'hFFFF_FFFF);
      // fill the table, then overwrite the last slot
      send_item(REQ_CARD, door_admin_id);
      repeat (MAX_USERS - 2) begin
         last_slot_id = $urandom;
         send_item(REQ_CARD, last_slot_id);
      end
      send_item(REQ_CARD, fresh_id);
      send_item(REQ_CARD, door_admin_id);
      send_item(REQ_CARD, last_slot_id);
      send_item(REQ_CARD, fresh_id);
      // admin card wins over a table entry with the same ID
      write_csr(CSR_ADMIN_ID, fresh_id);
      send_item(REQ_CARD, fresh_id);
      send_item(REQ_CARD, fresh_id);
   endtask

   // A new timeout applies only from the next restart of the countdown
   task automatic test_timeout_change();
      write_csr(CSR_TIMEOUT, 32'd3);
      send_item(REQ_CARD, door_admin_id);
      write_csr(CSR_TIMEOUT, 32'd6);
      repeat (3) send_item(REQ_TICK, $urandom);
      send_item(REQ_CARD, door_admin_id);
      send_item(REQ_TICK, $urandom);
      send_item(REQ_CARD, $urandom);
      repeat (6) send_item(REQ_TICK, $urandom);
   endtask

   // Hold the receiver off while items keep coming, then pause until all are back
   task automatic test_backpressure();
      write_csr(CSR_TIMEOUT, 32'd4);
      hold_req <= ~hold_req;
      repeat (24) send_mixed_item();
      wait_quiet();
   endtask

   task automatic test_random_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                                    input logic [31:0] admin, input logic [15:0] timeout_secs,
                                    input int unsigned count);
      int unsigned k;
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      write_csr(CSR_ADMIN_ID, admin);
      write_csr(CSR_TIMEOUT, {16'($urandom), timeout_secs});
      for (k = 0; k < POOL_SIZE; k++) id_pool[k] = $urandom;
      repeat (count) send_mixed_item();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_edge_cases();
      test_timeout_change();
      test_random_phase(30, 75, 32'h0000_0000, 16'($urandom_range(2, 6)), 50);
      test_random_phase(75, 30, 32'hFFFF_FFFF, 16'hFFFF, 50);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_backpressure();
      test_random_phase(0, 0, $urandom, 16'd1, 50);
      wait_quiet();
      if (mismatch_count == 0 && pending_events.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
